@@ sv/b64d_pkg.sv @@
// Shared types, status codes and the character lookup of the base64 stream decoder.
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD  = 2'd2;
    localparam logic [1:0] STATUS_TRUNC    = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       end_of_string;
    } in_beat_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       done_res;
        logic [1:0] status;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] group_phase;
        logic [5:0] leftover_bits;
        logic       pad_seen;
        logic [1:0] error_code;
    } dec_state_t;

    // Returns {hit, sextet}; hit is low for characters outside the alphabet.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
    endfunction

endpackage

@@ sv/b64d_core.sv @@
// Per-character decode step: next group state and the result for one beat.
module b64d_core (
    input  b64d_pkg::dec_state_t state,
    input  b64d_pkg::in_beat_t   beat,
    output b64d_pkg::dec_state_t state_next,
    output b64d_pkg::out_beat_t  result
);

    logic                 blank;
    logic [6:0]           sx;
    logic [5:0]           v;
    b64d_pkg::dec_state_t upd;

    assign blank = b64d_pkg::is_blank(beat.char_code);
    assign sx    = b64d_pkg::sextet_lookup(beat.char_code);
    assign v     = sx[5:0];

    always_comb
    begin
        upd    = state;
        result = '0;
        if (beat.char_present && !state.pad_seen &&
            state.error_code == b64d_pkg::STATUS_OK && !blank)
        begin
            if (beat.char_code == b64d_pkg::PAD_CHAR)
            begin
                if (state.group_phase < 2'd2)
                    upd.error_code = b64d_pkg::STATUS_BAD_PAD;
                else
                    upd.pad_seen = 1'b1;
            end
            else if (!sx[6])
            begin
                upd.error_code = b64d_pkg::STATUS_BAD_CHAR;
            end
            else
            begin
                unique case (state.group_phase)
                    2'd0:
                    begin
                        upd.leftover_bits = v;
                        upd.group_phase   = 2'd1;
                    end
                    2'd1:
                    begin
                        result.byte_valid = 1'b1;
                        result.byte_value = {state.leftover_bits, v[5:4]};
                        upd.leftover_bits = {2'b00, v[3:0]};
                        upd.group_phase   = 2'd2;
                    end
                    2'd2:
                    begin
                        result.byte_valid = 1'b1;
                        result.byte_value = {state.leftover_bits[3:0], v[5:2]};
                        upd.leftover_bits = {4'b0000, v[1:0]};
                        upd.group_phase   = 2'd3;
                    end
                    default:
                    begin
                        result.byte_valid = 1'b1;
                        result.byte_value = {state.leftover_bits[1:0], v};
                        upd.leftover_bits = '0;
                        upd.group_phase   = 2'd0;
                    end
                endcase
            end
        end

        // The ending beat reports status from the updated state and then clears it.
        if (beat.end_of_string)
        begin
            result.done_res = 1'b1;
            if (upd.error_code != b64d_pkg::STATUS_OK)
                result.status = upd.error_code;
            else if (!upd.pad_seen && upd.group_phase != 2'd0)
                result.status = b64d_pkg::STATUS_TRUNC;
            else
                result.status = b64d_pkg::STATUS_OK;
            state_next = '0;
        end
        else
        begin
            state_next = upd;
        end
    end

endmodule

@@ sv/base64_stream_decoder_top.sv @@
// Base64 stream decoder top level: input register, decode step and result register.
// An accepted beat is decoded from the input register into the result register.
// One beat per cycle unless the output stalls; every beat gives exactly one result beat.
// While a finished result waits on a stalled output, the input register takes one more beat.
// Reset (rst_n low, asynchronous) empties both registers and clears the group state.
module base64_stream_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_stall,
    input  b64d_pkg::in_beat_t  text_beat,
    output logic                res_valid,
    input  logic                res_stall,
    output b64d_pkg::out_beat_t res_beat
);

    // Input register: holds one accepted character beat.
    logic                 in_valid_reg;
    b64d_pkg::in_beat_t   in_data_reg;

    // Result register: holds one finished result beat.
    logic                 out_valid_reg;
    b64d_pkg::out_beat_t  out_data_reg;

    // Decoder state: group phase, leftover bits, pad flag and sticky error.
    b64d_pkg::dec_state_t state_reg;
    b64d_pkg::dec_state_t state_next;
    b64d_pkg::out_beat_t  result;

    logic advance;

    // The result register can load whenever it is empty or its beat is taken this cycle.
    assign advance    = !out_valid_reg || !res_stall;
    // The input side stalls only when its register is full and cannot move forward.
    assign text_stall = in_valid_reg && !advance;

    b64d_core u_core (
        .state      (state_reg),
        .beat       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!text_stall)
                in_valid_reg <= text_valid;
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                // The decoder state moves only when a character beat is consumed.
                if (in_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
            in_data_reg <= text_beat;
        if (advance && in_valid_reg)
            out_data_reg <= result;
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_data_reg;

endmodule

@@ sv/b64d_checker.sv @@
// Port-level checker for the base64 stream decoder, bound to its top level.
module b64d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                text_valid,
    input logic                text_stall,
    input b64d_pkg::in_beat_t  text_beat,
    input logic                res_valid,
    input logic                res_stall,
    input b64d_pkg::out_beat_t res_beat
);

    // The input side may stall only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (res_valid && res_stall))
        else $error("input stalled without a stalled result beat");

    // Status is only reported on the beat that ends the string.
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_beat.done_res) |-> (res_beat.status == b64d_pkg::STATUS_OK))
        else $error("status reported on a beat that does not end the string");

    // A beat without a decoded byte carries a zero byte value.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_beat.byte_valid) |-> (res_beat.byte_value == 8'h00))
        else $error("byte value set without byte_valid");

    // A stalled result beat stays in place.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_beat)))
        else $error("stalled result beat changed");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
